// ===== rtl/core/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants for the range second minimum block
// Holds the request and result payload types, the mode and status codes, and
// the queue entry passed from the front part to the back part.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int LEVELS_DEF = 11;
    localparam int POS_W      = 11;
    localparam int VAL_W      = 32;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [31:0] new_value;
        logic [10:0]       first_pos;
        logic [10:0]       last_pos;
    } req_t;

    typedef struct packed {
        logic signed [31:0] second_min;
        logic [1:0]        status;
    } rsp_t;

    // classified command from the front part
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_REPLY  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [1:0]        status;
        logic signed [31:0] value;
        logic [16:0]       lo;
        logic [16:0]       hi;
    } job_t;

    function automatic logic [4:0] flog2(input logic [16:0] n);
        logic [4:0] k;
        k = 5'd0;
        for (int i = 1; i < 17; i++) begin
            if (n[i])
            begin
                k = 5'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/rsm_front.sv =====
// ----------------------------------------------------------------------------
// rsm_front: request intake and classification
// Tracks the element count, validates requests and pushes jobs to a queue.
// ----------------------------------------------------------------------------
module rsm_front #(
    parameter int DEPTH  = rsm_pkg::DEPTH_DEF,
    parameter int LEVELS = rsm_pkg::LEVELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rsm_pkg::req_t in_data,
    output logic          job_valid,
    input  logic          job_full,
    output rsm_pkg::job_t job
);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [16:0]   fp, lp, cnt, len;
    logic          bad;

    assign in_stall  = job_full;
    assign job_valid = in_valid;
    assign fp  = 17'(in_data.first_pos);
    assign lp  = 17'(in_data.last_pos);
    assign cnt = 17'(count_reg);
    assign len = lp - fp + 17'd1;
    assign bad = (fp == 17'd0) || (lp > cnt) || (fp >= lp)
                 || (32'(rsm_pkg::flog2(len)) >= 32'(LEVELS));

    always_comb
    begin
        job.value  = in_data.new_value;
        job.lo     = fp - 17'd1;
        job.hi     = lp;
        job.status = rsm_pkg::ST_DONE;
        job.cmd    = rsm_pkg::CMD_REPLY;
        count_next = count_reg;
        case (in_data.mode)
            rsm_pkg::MODE_APPEND:
            begin
                if (cnt >= 17'(DEPTH))
                begin
                    job.status = rsm_pkg::ST_FULL;
                end
                else
                begin
                    job.cmd    = rsm_pkg::CMD_APPEND;
                    job.lo     = cnt;
                    count_next = count_reg + CW'(1);
                end
            end
            rsm_pkg::MODE_QUERY:
            begin
                if (bad)
                begin
                    job.status = rsm_pkg::ST_RANGE;
                end
                else
                begin
                    job.cmd = rsm_pkg::CMD_QUERY;
                end
            end
            rsm_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                job.cmd = rsm_pkg::CMD_REPLY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_valid && !job_full)
        begin
            count_reg <= count_next;
        end
    end
endmodule

// ===== rtl/core/rsm_queue.sv =====
// ----------------------------------------------------------------------------
// rsm_queue: short job queue
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module rsm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rsm_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output rsm_pkg::job_t head
);
    rsm_pkg::job_t ent_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && not_empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && not_empty);
        end
    end
endmodule

// ===== rtl/core/rsm_back.sv =====
// ----------------------------------------------------------------------------
// rsm_back: job execution
// Owns the element store and the sparse table; runs appends level by level
// and queries as a chain of range-argmin lookups.
// ----------------------------------------------------------------------------
module rsm_back #(
    parameter int DEPTH  = rsm_pkg::DEPTH_DEF,
    parameter int LEVELS = rsm_pkg::LEVELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_ready,
    input  rsm_pkg::job_t job,
    output logic          job_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output rsm_pkg::rsp_t out_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(LEVELS * DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_AP_T, S_AP_E, S_AP_W,
        S_RA_K, S_RA_T1, S_RA_T2, S_RA_E2, S_RA_PICK, S_OUT
    } state_t;

    // which lookup of a query is running
    typedef enum logic [1:0] {
        PH_TOP, PH_LEFT, PH_RIGHT, PH_LAST
    } phase_t;

    state_t             state_reg;
    phase_t             phase_reg;

    logic [31:0]        elem_mem [DEPTH];
    logic [AW-1:0]      tab_mem  [LEVELS * DEPTH];

    // memory ports
    logic [AW-1:0]      e_addr;
    logic [31:0]        e_rd_reg;
    logic [TW-1:0]      t_addr;
    logic [AW-1:0]      t_rd_reg;
    logic               t_we;
    logic [TW-1:0]      t_waddr;
    logic [AW-1:0]      t_wdata;

    logic [16:0]        n_reg, lo_reg, hi_reg, top_reg, rlo_reg, rhi_reg;
    logic [4:0]         lvl_reg, k_reg;
    logic [AW-1:0]      pa_reg, pb_reg, cur_pos_reg;
    logic signed [31:0] va_reg, cur_val_reg, left_reg, res_reg;
    logic [1:0]         st_reg;

    logic [16:0]        jj, top;
    logic signed [31:0] e_val, pick_val;
    logic [AW-1:0]      pick_pos;
    logic               b_wins, p1_wins, app_more;

    function automatic logic [TW-1:0] taddr(input logic [4:0] l,
                                            input logic [16:0] j);
        return TW'(int'(l) * DEPTH + int'(j));
    endfunction

    assign out_valid           = (state_reg == S_OUT);
    assign out_data.second_min = res_reg;
    assign out_data.status     = st_reg;
    assign job_pop             = (state_reg == S_IDLE) && job_ready;

    // element reads always follow the table read data
    assign e_addr   = t_rd_reg;
    assign e_val    = $signed(e_rd_reg);
    assign jj       = n_reg + 17'd1 - (17'd1 << lvl_reg);
    // append: the window ending at n wins only when strictly smaller
    assign b_wins   = cur_val_reg < e_val;
    // query: the right lookup wins a tie
    assign p1_wins  = va_reg < e_val;
    assign pick_pos = p1_wins ? pa_reg : pb_reg;
    assign pick_val = p1_wins ? va_reg : e_val;
    assign top      = 17'(pick_pos);
    assign app_more = (int'(lvl_reg) + 1 < LEVELS)
                      && ({1'b0, n_reg} + 18'd1 >= (18'd1 << (lvl_reg + 5'd1)));

    always_ff @(posedge clk)
    begin
        e_rd_reg <= elem_mem[e_addr];
        t_rd_reg <= tab_mem[t_addr];
        if (t_we)
        begin
            tab_mem[t_waddr] <= t_wdata;
        end
        if (job_pop && job.cmd == rsm_pkg::CMD_APPEND)
        begin
            elem_mem[job.lo[AW-1:0]] <= job.value;
        end
    end

    always_comb
    begin
        t_addr  = taddr(lvl_reg - 5'd1, jj);
        t_we    = 1'b0;
        t_waddr = taddr(lvl_reg, jj);
        t_wdata = b_wins ? cur_pos_reg : pa_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_pop && job.cmd == rsm_pkg::CMD_APPEND)
                begin
                    t_we    = 1'b1;
                    t_waddr = taddr(5'd0, job.lo);
                    t_wdata = job.lo[AW-1:0];
                end
            end
            S_AP_W:
            begin
                t_we = 1'b1;
            end
            S_RA_T1:
            begin
                t_addr = taddr(k_reg, rlo_reg);
            end
            S_RA_T2:
            begin
                t_addr = taddr(k_reg, rhi_reg - (17'd1 << k_reg));
            end
            default:
            begin
                t_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_TOP;
            res_reg     <= '0;
            st_reg      <= '0;
            n_reg       <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            top_reg     <= '0;
            rlo_reg     <= '0;
            rhi_reg     <= '0;
            lvl_reg     <= '0;
            k_reg       <= '0;
            pa_reg      <= '0;
            pb_reg      <= '0;
            cur_pos_reg <= '0;
            va_reg      <= '0;
            cur_val_reg <= '0;
            left_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_ready)
                    begin
                        res_reg     <= '0;
                        st_reg      <= job.status;
                        n_reg       <= job.lo;
                        lo_reg      <= job.lo;
                        hi_reg      <= job.hi;
                        rlo_reg     <= job.lo;
                        rhi_reg     <= job.hi;
                        lvl_reg     <= 5'd1;
                        phase_reg   <= PH_TOP;
                        cur_pos_reg <= job.lo[AW-1:0];
                        cur_val_reg <= job.value;
                        case (job.cmd)
                            rsm_pkg::CMD_APPEND:
                            begin
                                // the first element completes no upper level
                                state_reg <= (job.lo == 17'd0) ? S_OUT : S_AP_T;
                            end
                            rsm_pkg::CMD_QUERY:
                            begin
                                state_reg <= S_RA_K;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                // append level: read left half argmin, read its value, write
                S_AP_T:
                begin
                    state_reg <= S_AP_E;
                end
                S_AP_E:
                begin
                    pa_reg    <= t_rd_reg;
                    state_reg <= S_AP_W;
                end
                S_AP_W:
                begin
                    if (!b_wins)
                    begin
                        cur_pos_reg <= pa_reg;
                        cur_val_reg <= e_val;
                    end
                    lvl_reg   <= lvl_reg + 5'd1;
                    state_reg <= app_more ? S_AP_T : S_OUT;
                end
                // range argmin of [rlo, rhi): two table reads, two value reads
                S_RA_K:
                begin
                    k_reg     <= rsm_pkg::flog2(rhi_reg - rlo_reg);
                    state_reg <= S_RA_T1;
                end
                S_RA_T1:
                begin
                    state_reg <= S_RA_T2;
                end
                S_RA_T2:
                begin
                    pa_reg    <= t_rd_reg;
                    state_reg <= S_RA_E2;
                end
                S_RA_E2:
                begin
                    pb_reg    <= t_rd_reg;
                    va_reg    <= e_val;
                    state_reg <= S_RA_PICK;
                end
                S_RA_PICK:
                begin
                    case (phase_reg)
                        PH_TOP:
                        begin
                            state_reg <= S_RA_K;
                            if (top == lo_reg)
                            begin
                                rlo_reg   <= top + 17'd1;
                                rhi_reg   <= hi_reg;
                                phase_reg <= PH_LAST;
                            end
                            else if (top == hi_reg - 17'd1)
                            begin
                                rlo_reg   <= lo_reg;
                                rhi_reg   <= top;
                                phase_reg <= PH_LAST;
                            end
                            else
                            begin
                                top_reg   <= top;
                                rlo_reg   <= lo_reg;
                                rhi_reg   <= top;
                                phase_reg <= PH_LEFT;
                            end
                        end
                        PH_LEFT:
                        begin
                            left_reg  <= pick_val;
                            rlo_reg   <= top_reg + 17'd1;
                            rhi_reg   <= hi_reg;
                            phase_reg <= PH_RIGHT;
                            state_reg <= S_RA_K;
                        end
                        PH_RIGHT:
                        begin
                            res_reg   <= (pick_val < left_reg) ? pick_val : left_reg;
                            state_reg <= S_OUT;
                        end
                        default:
                        begin
                            res_reg   <= pick_val;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/range_second_minimum.sv =====
// ----------------------------------------------------------------------------
// range_second_minimum: second smallest value of a range via a sparse table
// Front part classifies requests, a queue decouples it from the back part.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  in      | in_valid, in_stall, in_data    | request in
//  out     | out_valid, out_stall, out_data | result out
//  a request is held in the queue until the back part takes it in its idle state
//  append: states S_AP_T, S_AP_E, S_AP_W for each table level it completes (up to LEVELS - 1 levels)
//  query: states S_RA_K, S_RA_T1, S_RA_T2, S_RA_E2, S_RA_PICK per range lookup, two or three lookups
//  full store, bad range, clear and unused mode go straight to the result
//  no clearing pass after reset: stores are written before they are read
//  a stalled result holds the back part; the queue keeps accepting two jobs
module range_second_minimum #(
    parameter int DEPTH  = rsm_pkg::DEPTH_DEF,
    parameter int LEVELS = rsm_pkg::LEVELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rsm_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output rsm_pkg::rsp_t out_data
);
    logic          jv, jfull, jpop, jne;
    rsm_pkg::job_t jin, jhead;

    rsm_front #(.DEPTH(DEPTH), .LEVELS(LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .job_valid(jv), .job_full(jfull), .job(jin));

    rsm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(jv), .push_data(jin), .full(jfull),
        .pop(jpop), .not_empty(jne), .head(jhead));

    rsm_back #(.DEPTH(DEPTH), .LEVELS(LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_ready(jne), .job(jhead), .job_pop(jpop),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
endmodule

// ===== rtl/core/rsm_checker.sv =====
// ----------------------------------------------------------------------------
// rsm_checker: port-level checks
// Watches the handshakes and result codes of the top level.
// ----------------------------------------------------------------------------
module rsm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input rsm_pkg::rsp_t out_data
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("request withdrawn while stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != rsm_pkg::ST_RSVD)
        else $error("reserved status");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != rsm_pkg::ST_DONE |-> out_data.second_min == 0)
        else $error("nonzero value on error");
endmodule

bind range_second_minimum rsm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
